// ----- sv/cgsp_pkg.sv -----
// Shared types and codes for the closed grid scan path generator.
// No dependencies; the top level imports this package.
package cgsp_pkg;

    localparam int CGSP_MAX_POINTS = 4096;
    localparam int COORD_W         = 16;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [1:0]                status_t;
    typedef logic [1:0]                cfg_index_t;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_DONE  = 2'd1;
    localparam status_t STATUS_ERROR = 2'd2;

    localparam cfg_index_t CFG_X_LOW  = 2'd0;
    localparam cfg_index_t CFG_X_HIGH = 2'd1;
    localparam cfg_index_t CFG_Y_LOW  = 2'd2;
    localparam cfg_index_t CFG_Y_HIGH = 2'd3;

endpackage

// ----- sv/cgsp_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Used as the point store of the scan path generator; no dependencies.
module cgsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/closed_grid_scan_path_generator.sv -----
// Top level of the closed grid scan path generator: sequencer, path builder and read-out.
// Depends on cgsp_pkg and on cgsp_ram for the point store.
//
//  Channel   Direction  Handshake             Payload
//  input     in         in_valid / in_stall   kind, prev_direction
//  result    out        out_valid / out_stall status, point_x, point_y, last, chosen_direction
//  config    in         cfg_we                cfg_index, cfg_data
//
// A next request passes a store read, then the result register, before the next input
// transfer. A restart passes the dimension and size states, then the builder, writing one
// point per cycle through the single store write port, then the result register; a rejected
// grid skips the builder. Reset clears the control state and the path bookkeeping, not the store.
// Input is stalled while an item is in work; a stalled result waits in its register.
module closed_grid_scan_path_generator
#(
    parameter int MAX_POINTS = cgsp_pkg::CGSP_MAX_POINTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic                 prev_direction,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cgsp_pkg::status_t    status,
    output cgsp_pkg::coord_t     point_x,
    output cgsp_pkg::coord_t     point_y,
    output logic                 last,
    output logic                 chosen_direction,
    input  logic                 cfg_we,
    input  cgsp_pkg::cfg_index_t cfg_index,
    input  cgsp_pkg::coord_t     cfg_data
);
    import cgsp_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int DW = $clog2(MAX_POINTS + 1);
    localparam int LW = $clog2(MAX_POINTS + 2);
    localparam int SW = COORD_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIM   = 3'd1;
    localparam logic [2:0] S_SIZE  = 3'd2;
    localparam logic [2:0] S_BUILD = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [3:0] PH_L1   = 4'd0;
    localparam logic [3:0] PH_L2   = 4'd1;
    localparam logic [3:0] PH_COL0 = 4'd2;
    localparam logic [3:0] PH_BOT  = 4'd3;
    localparam logic [3:0] PH_SERP = 4'd4;
    localparam logic [3:0] PH_TOP  = 4'd5;
    localparam logic [3:0] PH_SQ   = 4'd6;
    localparam logic [3:0] PH_LOOP = 4'd7;
    localparam logic [3:0] PH_LAST = 4'd8;

    localparam logic [2*SW-1:0] MAX_PROD = (2*SW)'(MAX_POINTS);

    // configuration
    coord_t x_low_reg, x_high_reg, y_low_reg, y_high_reg;

    // control and path bookkeeping
    logic [2:0]    state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [AW-1:0] start_reg, start_next;
    logic [LW-1:0] emitted_reg, emitted_next;
    logic          ready_reg, ready_next;
    logic          err_reg, err_next;
    logic          dir_reg, dir_next;
    logic          prev_reg, prev_next;

    // pending result
    status_t res_status_reg, res_status_next;
    logic    res_pt_reg, res_pt_next;
    logic    res_last_reg, res_last_next;

    // grid dimension stage
    logic [SW-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic [DW-1:0] aox_reg, aox_next, aoy_reg, aoy_next;
    logic          bad_reg, bad_next;

    // path builder
    logic [3:0]    phase_reg, phase_next;
    logic [DW-1:0] r_reg, r_next, c_reg, c_next;
    logic [DW-1:0] rows_reg, rows_next, cols_reg, cols_next;
    logic [DW-1:0] a_reg, a_next, ar_reg, ar_next, ac_reg, ac_next;
    logic          dec_reg, dec_next;
    logic [1:0]    sub_reg, sub_next;
    logic          swap_reg, swap_next;
    logic          odd_reg, odd_next;
    logic          is2d_reg, is2d_next;
    logic [LW-1:0] fill_reg, fill_next;

    // output register
    logic    out_valid_reg;
    status_t out_status_reg;
    coord_t  out_x_reg, out_y_reg;
    logic    out_last_reg, out_dir_reg;

    // store ports
    logic                    wr_en, rd_en;
    logic [AW-1:0]           rd_addr;
    logic [2*COORD_W-1:0]    wr_data, rd_data;

    logic          in_fire, out_free;
    logic          seg_end, fin;
    coord_t        px, py;
    coord_t        ax, ay;
    logic [SW-1:0] ax_off, ay_off;
    logic [2*SW-1:0] prod;
    logic [DW-1:0] line_n, line_a, rows_2d, cols_2d;
    logic [DW:0]   a_twice;
    logic          dir_2d;
    logic [LW-1:0] stored;
    logic [LW:0]   idx_sum;
    logic [LW:0]   idx;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // point of the builder in grid coordinates
    assign px = coord_t'(x_low_reg + coord_t'(swap_reg ? r_reg : c_reg));
    assign py = coord_t'(y_low_reg + coord_t'(swap_reg ? c_reg : r_reg));
    assign wr_data = {py, px};
    assign wr_en   = (state_reg == S_BUILD);

    // read-out index: rotation by the start offset, the closing point back at the anchor
    assign stored  = (len_reg == LW'(1)) ? LW'(1) : LW'(len_reg - LW'(1));
    assign idx_sum = (LW+1)'(start_reg) + (LW+1)'(emitted_reg);
    always_comb
    begin
        if (emitted_reg >= stored)
        begin
            idx = (LW+1)'(start_reg);
        end
        else if (idx_sum >= (LW+1)'(stored))
        begin
            idx = idx_sum - (LW+1)'(stored);
        end
        else
        begin
            idx = idx_sum;
        end
    end
    assign rd_addr = idx[AW-1:0];

    // anchor: zero where the range holds it, otherwise the bound nearest zero
    always_comb
    begin
        ax = (x_low_reg > 0) ? x_low_reg : ((x_high_reg < 0) ? x_high_reg : '0);
        ay = (y_low_reg > 0) ? y_low_reg : ((y_high_reg < 0) ? y_high_reg : '0);
        ax_off = SW'({ax[COORD_W-1], ax} - {x_low_reg[COORD_W-1], x_low_reg});
        ay_off = SW'({ay[COORD_W-1], ay} - {y_low_reg[COORD_W-1], y_low_reg});
    end

    assign prod    = nx_reg * ny_reg;
    assign line_n  = (ny_reg == SW'(1)) ? nx_reg[DW-1:0] : ny_reg[DW-1:0];
    assign line_a  = (ny_reg == SW'(1)) ? aox_reg : aoy_reg;
    assign a_twice = (DW+1)'(line_a) + (DW+1)'(line_a);
    // equal parity alternates; otherwise rows run parallel to the odd side
    assign dir_2d  = (nx_reg[0] == ny_reg[0]) ? !prev_reg : !ny_reg[0];
    assign rows_2d = dir_2d ? ny_reg[DW-1:0] : nx_reg[DW-1:0];
    assign cols_2d = dir_2d ? nx_reg[DW-1:0] : ny_reg[DW-1:0];

    // segment end for the moving column
    assign seg_end = dec_reg ? (c_reg == ((phase_reg == PH_SERP) ? DW'(1) : '0))
                             : (c_reg == DW'(cols_reg - DW'(1)));

    // path builder step
    always_comb
    begin
        phase_next = phase_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        dec_next   = dec_reg;
        sub_next   = sub_reg;
        fin        = 1'b0;
        unique case (phase_reg)
            PH_L1:
            begin
                if (seg_end)
                begin
                    if (cols_reg == DW'(1))
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_L2;
                        c_next     = dec_reg ? DW'(a_reg + DW'(1)) : DW'(a_reg - DW'(1));
                        dec_next   = !dec_reg;
                    end
                end
                else
                begin
                    c_next = dec_reg ? DW'(c_reg - DW'(1)) : DW'(c_reg + DW'(1));
                end
            end
            PH_L2:
            begin
                if (seg_end)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    c_next = dec_reg ? DW'(c_reg - DW'(1)) : DW'(c_reg + DW'(1));
                end
            end
            PH_COL0:
            begin
                if (r_reg == DW'(rows_reg - DW'(1)))
                begin
                    phase_next = odd_reg ? PH_BOT : PH_SERP;
                    c_next     = DW'(1);
                    dec_next   = 1'b0;
                end
                else
                begin
                    r_next = DW'(r_reg + DW'(1));
                end
            end
            PH_BOT:
            begin
                if (c_reg == DW'(cols_reg - DW'(1)))
                begin
                    if (rows_reg > DW'(3))
                    begin
                        phase_next = PH_SERP;
                        r_next     = DW'(rows_reg - DW'(2));
                        dec_next   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SQ;
                        r_next     = DW'(1);
                        sub_next   = 2'd0;
                    end
                end
                else
                begin
                    c_next = DW'(c_reg + DW'(1));
                end
            end
            PH_SERP:
            begin
                if (seg_end)
                begin
                    if (r_reg == (odd_reg ? DW'(2) : DW'(1)))
                    begin
                        phase_next = odd_reg ? PH_SQ : PH_TOP;
                        r_next     = odd_reg ? DW'(1) : '0;
                        c_next     = DW'(cols_reg - DW'(1));
                        dec_next   = 1'b1;
                        sub_next   = 2'd0;
                    end
                    else
                    begin
                        r_next   = DW'(r_reg - DW'(1));
                        dec_next = !dec_reg;
                    end
                end
                else
                begin
                    c_next = dec_reg ? DW'(c_reg - DW'(1)) : DW'(c_reg + DW'(1));
                end
            end
            PH_TOP:
            begin
                if (c_reg == DW'(1))
                begin
                    fin = 1'b1;
                end
                else
                begin
                    c_next = DW'(c_reg - DW'(1));
                end
            end
            PH_SQ:
            begin
                unique case (sub_reg)
                    2'd0:
                    begin
                        c_next   = DW'(cols_reg - DW'(2));
                        sub_next = 2'd1;
                    end
                    2'd1:
                    begin
                        r_next   = '0;
                        c_next   = DW'(cols_reg - DW'(1));
                        sub_next = 2'd2;
                    end
                    default:
                    begin
                        r_next = '0;
                        if (cols_reg >= DW'(4))
                        begin
                            phase_next = PH_LOOP;
                            c_next     = DW'(cols_reg - DW'(2));
                            sub_next   = 2'd0;
                        end
                        else
                        begin
                            phase_next = PH_LAST;
                            c_next     = DW'(1);
                        end
                    end
                endcase
            end
            PH_LOOP:
            begin
                // squiggle of four points per column pair along the first two rows
                unique case (sub_reg)
                    2'd0:
                    begin
                        c_next   = DW'(c_reg - DW'(1));
                        sub_next = 2'd1;
                    end
                    2'd1:
                    begin
                        r_next   = DW'(1);
                        sub_next = 2'd2;
                    end
                    2'd2:
                    begin
                        c_next   = DW'(c_reg - DW'(1));
                        sub_next = 2'd3;
                    end
                    default:
                    begin
                        r_next = '0;
                        if (c_reg >= DW'(2))
                        begin
                            sub_next = 2'd0;
                        end
                        else
                        begin
                            phase_next = PH_LAST;
                            c_next     = DW'(1);
                        end
                    end
                endcase
            end
            default:
            begin
                fin = 1'b1;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        start_next      = start_reg;
        emitted_next    = emitted_reg;
        ready_next      = ready_reg;
        err_next        = err_reg;
        dir_next        = dir_reg;
        prev_next       = prev_reg;
        res_status_next = res_status_reg;
        res_pt_next     = res_pt_reg;
        res_last_next   = res_last_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        aox_next        = aox_reg;
        aoy_next        = aoy_reg;
        bad_next        = bad_reg;
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        a_next          = a_reg;
        ar_next         = ar_reg;
        ac_next         = ac_reg;
        swap_next       = swap_reg;
        odd_next        = odd_reg;
        is2d_next       = is2d_reg;
        fill_next       = fill_reg;
        rd_en           = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_pt_next   = 1'b0;
                    res_last_next = 1'b0;
                    if (!kind)
                    begin
                        ready_next   = 1'b0;
                        err_next     = 1'b0;
                        emitted_next = '0;
                        len_next     = '0;
                        start_next   = '0;
                        dir_next     = prev_direction;
                        prev_next    = prev_direction;
                        state_next   = S_DIM;
                    end
                    else if (err_reg)
                    begin
                        res_status_next = STATUS_ERROR;
                        state_next      = S_OUT;
                    end
                    else if (!ready_reg || emitted_reg >= len_reg)
                    begin
                        res_status_next = STATUS_DONE;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        rd_en           = 1'b1;
                        res_status_next = STATUS_OK;
                        res_pt_next     = 1'b1;
                        res_last_next   = (LW'(emitted_reg + LW'(1)) == len_reg);
                        emitted_next    = LW'(emitted_reg + LW'(1));
                        state_next      = S_OUT;
                    end
                end
            end
            S_DIM:
            begin
                nx_next  = SW'({x_high_reg[COORD_W-1], x_high_reg}
                               - {x_low_reg[COORD_W-1], x_low_reg} + SW'(1));
                ny_next  = SW'({y_high_reg[COORD_W-1], y_high_reg}
                               - {y_low_reg[COORD_W-1], y_low_reg} + SW'(1));
                bad_next = (x_low_reg > x_high_reg) || (y_low_reg > y_high_reg);
                aox_next = ax_off[DW-1:0];
                aoy_next = ay_off[DW-1:0];
                state_next = S_SIZE;
            end
            S_SIZE:
            begin
                fill_next = '0;
                if (bad_reg || prod > MAX_PROD)
                begin
                    err_next        = 1'b1;
                    res_status_next = STATUS_ERROR;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_BUILD;
                    if (nx_reg == SW'(1) || ny_reg == SW'(1))
                    begin
                        is2d_next = 1'b0;
                        swap_next = (ny_reg != SW'(1));
                        rows_next = DW'(1);
                        cols_next = line_n;
                        a_next    = line_a;
                    end
                    else
                    begin
                        is2d_next = 1'b1;
                        dir_next  = dir_2d;
                        swap_next = !dir_2d;
                        rows_next = rows_2d;
                        cols_next = cols_2d;
                        odd_next  = rows_2d[0];
                        ar_next   = dir_2d ? aoy_reg : aox_reg;
                        ac_next   = dir_2d ? aox_reg : aoy_reg;
                    end
                end
            end
            S_BUILD:
            begin
                fill_next = LW'(fill_reg + LW'(1));
                if (is2d_reg && r_reg == ar_reg && c_reg == ac_reg)
                begin
                    start_next = fill_reg[AW-1:0];
                end
                if (fin)
                begin
                    len_next        = (!is2d_reg && fill_reg == '0) ? LW'(1)
                                                                    : LW'(fill_reg + LW'(2));
                    ready_next      = 1'b1;
                    res_status_next = STATUS_OK;
                    state_next      = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // start values of the builder, taken in the grid check cycle
    logic          init_dec;
    assign init_dec = (a_twice <= (DW+1)'(line_n) - (DW+1)'(1));

    always_ff @(posedge clk)
    begin
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        aox_reg  <= aox_next;
        aoy_reg  <= aoy_next;
        bad_reg  <= bad_next;
        rows_reg <= rows_next;
        cols_reg <= cols_next;
        a_reg    <= a_next;
        ar_reg   <= ar_next;
        ac_reg   <= ac_next;
        swap_reg <= swap_next;
        odd_reg  <= odd_next;
        is2d_reg <= is2d_next;
        fill_reg <= fill_next;
        if (state_reg == S_SIZE)
        begin
            if (nx_reg == SW'(1) || ny_reg == SW'(1))
            begin
                phase_reg <= PH_L1;
                r_reg     <= '0;
                c_reg     <= line_a;
                dec_reg   <= init_dec;
            end
            else
            begin
                phase_reg <= PH_COL0;
                r_reg     <= '0;
                c_reg     <= '0;
                dec_reg   <= 1'b0;
            end
            sub_reg <= 2'd0;
        end
        else if (state_reg == S_BUILD)
        begin
            phase_reg <= phase_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            dec_reg   <= dec_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg      <= '0;
            x_high_reg     <= '0;
            y_low_reg      <= '0;
            y_high_reg     <= '0;
            state_reg      <= S_IDLE;
            len_reg        <= '0;
            start_reg      <= '0;
            emitted_reg    <= '0;
            ready_reg      <= 1'b0;
            err_reg        <= 1'b0;
            dir_reg        <= 1'b0;
            prev_reg       <= 1'b0;
            res_status_reg <= STATUS_OK;
            res_pt_reg     <= 1'b0;
            res_last_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_last_reg   <= 1'b0;
            out_dir_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_X_LOW:  x_low_reg  <= cfg_data;
                    CFG_X_HIGH: x_high_reg <= cfg_data;
                    CFG_Y_LOW:  y_low_reg  <= cfg_data;
                    default:    y_high_reg <= cfg_data;
                endcase
            end
            state_reg      <= state_next;
            len_reg        <= len_next;
            start_reg      <= start_next;
            emitted_reg    <= emitted_next;
            ready_reg      <= ready_next;
            err_reg        <= err_next;
            dir_reg        <= dir_next;
            prev_reg       <= prev_next;
            res_status_reg <= res_status_next;
            res_pt_reg     <= res_pt_next;
            res_last_reg   <= res_last_next;
            // the store read data is valid in the cycle after the request transfer
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= res_status_reg;
                out_x_reg      <= res_pt_reg ? coord_t'(rd_data[COORD_W-1:0]) : '0;
                out_y_reg      <= res_pt_reg ? coord_t'(rd_data[2*COORD_W-1:COORD_W]) : '0;
                out_last_reg   <= res_last_reg;
                out_dir_reg    <= dir_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    cgsp_ram #(
        .WIDTH (2*COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign point_x          = out_x_reg;
    assign point_y          = out_y_reg;
    assign last             = out_last_reg;
    assign chosen_direction = out_dir_reg;

    a_ready_not_error: assert property (@(posedge clk) disable iff (!rst_n)
        !(ready_reg && err_reg))
        else $error("path ready and grid error both set");

    a_emitted_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (emitted_reg <= len_reg) && (len_reg != '0))
        else $error("emitted count beyond path length");

    a_start_in_path: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (LW'(start_reg) < len_reg))
        else $error("start offset outside the built path");

    a_build_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUILD) |-> (fill_reg < LW'(MAX_POINTS)))
        else $error("builder ran past the store");

    a_build_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUILD) |-> !ready_reg && !err_reg)
        else $error("path flagged ready while still building");

endmodule
